### sv/triplet_margin_accuracy_top_macros.svh
// Assertion macros used by the checker file of the triplet margin accuracy block.
`ifndef TRIPLET_MARGIN_ACCURACY_TOP_MACROS_SVH
`define TRIPLET_MARGIN_ACCURACY_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is low.
`define TMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/tma_pkg.sv
// Package with widths, states and control types of the triplet margin accuracy block.
`timescale 1ns / 1ps
`default_nettype none

package tma_pkg;

  localparam int FEATURE_BITS = 16;
  localparam int DIFF_W       = FEATURE_BITS + 1;
  localparam int SQ_W         = 2 * FEATURE_BITS;
  localparam int ACC_W        = 48;
  localparam int VERD_W       = ACC_W + 2;
  localparam int CNT_W        = 13;
  localparam int MAX_BATCH    = 4096;
  localparam int ACCQ_W       = 17;
  localparam int DIV_STEPS    = ACCQ_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int REM_W        = CNT_W;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 64;

  localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [ACCQ_W-1:0] ACCQ_ONE = ACCQ_W'(1) << (ACCQ_W - 1);

  // Register index taken from the byte address (8 bytes per register).
  localparam logic REG_MARGIN = 1'b0;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_FOLD,
    ST_JUDGE,
    ST_DIV,
    ST_EMIT
  } tma_state_t;

  typedef struct packed {
    logic sq_load;
    logic acc_add;
    logic judge;
    logic div_step;
    logic div_first;
    logic emit;
  } tma_cmd_t;

  typedef struct packed {
    logic last_sample;
  } tma_stat_t;

endpackage

`default_nettype wire

### sv/tma_ctrl.sv
// Controller state machine that sequences accumulation, judgment, division and output.
`timescale 1ns / 1ps
`default_nettype none

module tma_ctrl
  import tma_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last_channel,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire tma_stat_t stat,
  output tma_cmd_t      cmd
);

  tma_state_t           state_r, state_nxt;
  logic                 sq_pend_r, sq_pend_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      sq_pend_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_pend_r   <= sq_pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (accept && in_last_channel) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd.judge = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.last_sample ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
    cmd.sq_load   = accept;
    cmd.acc_add   = sq_pend_r;
    sq_pend_nxt   = accept;
    out_valid_nxt = cmd.emit ? 1'b1 : (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### sv/tma_datapath.sv
// Datapath with squarers, saturating distance accumulators, counters and the accuracy divider.
`timescale 1ns / 1ps
`default_nettype none

module tma_datapath
  import tma_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic signed [FEATURE_BITS-1:0] in_anchor_value,
  input  wire logic signed [FEATURE_BITS-1:0] in_positive_value,
  input  wire logic signed [FEATURE_BITS-1:0] in_negative_value,
  input  wire logic                     in_last_sample,
  input  wire logic [ACC_W-1:0]         margin,
  input  wire tma_cmd_t                 cmd,
  output tma_stat_t                     stat,
  output logic                          out_sample_correct,
  output logic                          out_batch_done,
  output logic [CNT_W-1:0]              out_correct_total,
  output logic [CNT_W-1:0]              out_samples_total,
  output logic [ACCQ_W-1:0]             out_batch_accuracy
);

  logic signed [DIFF_W-1:0] diff_ap, diff_an;
  logic [DIFF_W-1:0]        mag_ap, mag_an;
  logic [2*DIFF_W-1:0]      prod_ap, prod_an;
  logic [SQ_W-1:0]          sq_ap_r, sq_an_r;
  logic                     last_smp_r;

  logic [ACC_W-1:0]         acc_ap_r, acc_ap_nxt, acc_an_r, acc_an_nxt;
  logic [ACC_W:0]           sum_ap, sum_an;
  logic [VERD_W-1:0]        verdict;
  logic                     correct;

  logic [CNT_W-1:0]         cc_r, cc_nxt, sc_r, sc_nxt;
  logic [CNT_W-1:0]         cc_upd, sc_upd;
  logic                     res_correct_r, res_last_r;
  logic [CNT_W-1:0]         res_cc_r, res_sc_r;

  logic [REM_W-1:0]         rem_r;
  logic [REM_W:0]           trial, trial_sub;
  logic                     ge;
  logic [ACCQ_W-1:0]        q_r;

  // Squared channel distances, registered before accumulation.
  always_comb begin
    diff_ap = DIFF_W'(in_anchor_value) - DIFF_W'(in_positive_value);
    diff_an = DIFF_W'(in_anchor_value) - DIFF_W'(in_negative_value);
    mag_ap  = diff_ap[DIFF_W-1] ? DIFF_W'(-diff_ap) : DIFF_W'(diff_ap);
    mag_an  = diff_an[DIFF_W-1] ? DIFF_W'(-diff_an) : DIFF_W'(diff_an);
    prod_ap = (2*DIFF_W)'(mag_ap) * (2*DIFF_W)'(mag_ap);
    prod_an = (2*DIFF_W)'(mag_an) * (2*DIFF_W)'(mag_an);
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_ap_r    <= prod_ap[SQ_W-1:0];
      sq_an_r    <= prod_an[SQ_W-1:0];
      last_smp_r <= in_last_sample;
    end
  end

  assign stat.last_sample = last_smp_r;

  // Saturating accumulation and the sample verdict.
  always_comb begin
    sum_ap  = {1'b0, acc_ap_r} + (ACC_W+1)'(sq_ap_r);
    sum_an  = {1'b0, acc_an_r} + (ACC_W+1)'(sq_an_r);
    verdict = {{(VERD_W-ACC_W){margin[ACC_W-1]}}, margin} + VERD_W'(acc_ap_r)
              - VERD_W'(acc_an_r);
    correct = verdict[VERD_W-1] || (verdict == '0);

    acc_ap_nxt = acc_ap_r;
    acc_an_nxt = acc_an_r;
    if (cmd.acc_add) begin
      acc_ap_nxt = sum_ap[ACC_W] ? ACC_MAX : sum_ap[ACC_W-1:0];
      acc_an_nxt = sum_an[ACC_W] ? ACC_MAX : sum_an[ACC_W-1:0];
    end else if (cmd.judge) begin
      acc_ap_nxt = '0;
      acc_an_nxt = '0;
    end

    cc_upd = cc_r;
    sc_upd = sc_r;
    if (sc_r < CNT_W'(MAX_BATCH)) begin
      sc_upd = sc_r + 1'b1;
      cc_upd = cc_r + CNT_W'(correct);
    end
    cc_nxt = cc_r;
    sc_nxt = sc_r;
    if (cmd.judge) begin
      cc_nxt = last_smp_r ? '0 : cc_upd;
      sc_nxt = last_smp_r ? '0 : sc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_ap_r <= '0;
      acc_an_r <= '0;
      cc_r     <= '0;
      sc_r     <= '0;
    end else begin
      acc_ap_r <= acc_ap_nxt;
      acc_an_r <= acc_an_nxt;
      cc_r     <= cc_nxt;
      sc_r     <= sc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      res_correct_r <= correct;
      res_last_r    <= last_smp_r;
      res_cc_r      <= cc_upd;
      res_sc_r      <= sc_upd;
    end
  end

  // Restoring divider: one quotient bit of (correct << 16) / samples per step.
  always_comb begin
    trial     = cmd.div_first ? {1'b0, res_cc_r} : {rem_r, 1'b0};
    ge        = (trial >= {1'b0, res_sc_r});
    trial_sub = trial - {1'b0, res_sc_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      q_r   <= {q_r[ACCQ_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_correct <= res_correct_r;
      out_batch_done     <= res_last_r;
      out_correct_total  <= res_cc_r;
      out_samples_total  <= res_sc_r;
      out_batch_accuracy <= res_last_r ? q_r : '0;
    end
  end

endmodule

`default_nettype wire

### sv/triplet_margin_accuracy_top.sv
// Top level of the triplet margin accuracy block with its margin register port.
//
//   Channel  Direction  Handshake              Contents
//   in_      input      in_valid / in_stall    one feature channel of a triplet
//   out_     output     out_valid / out_stall  per-sample verdict and batch accuracy
//   cfg      input      psel/penable/pready    margin register at byte address 0
//
// A channel that does not close a sample is accepted directly; channels stream back to back.
// The last channel of a sample passes in turn through accept, fold, judge and output load.
// The last sample of a batch also runs the bit-serial accuracy divider before the output load.
// The output register frees the input side; a stalled result holds only the output load.
// Reset is synchronous and active low; it clears margin, accumulators and counters.
`timescale 1ns / 1ps
`default_nettype none

module triplet_margin_accuracy_top
  import tma_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [FEATURE_BITS-1:0] in_anchor_value,
  input  wire logic signed [FEATURE_BITS-1:0] in_positive_value,
  input  wire logic signed [FEATURE_BITS-1:0] in_negative_value,
  input  wire logic                           in_last_channel,
  input  wire logic                           in_last_sample,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_sample_correct,
  output logic                                out_batch_done,
  output logic [CNT_W-1:0]                    out_correct_total,
  output logic [CNT_W-1:0]                    out_samples_total,
  output logic [ACCQ_W-1:0]                   out_batch_accuracy,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ADDR_W-1:0]              paddr,
  input  wire logic [DATA_W-1:0]              pwdata,
  output logic [DATA_W-1:0]                   prdata,
  output logic                                pready
);

  logic [ACC_W-1:0] margin_r, margin_nxt;
  tma_cmd_t         cmd;
  tma_stat_t        stat;

  assign pready = 1'b1;

  always_comb begin
    margin_nxt = margin_r;
    if (psel && penable && pwrite && pready && (paddr[3] == REG_MARGIN)) begin
      margin_nxt = pwdata[ACC_W-1:0];
    end
    prdata = (paddr[3] == REG_MARGIN) ? DATA_W'(margin_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else begin
      margin_r <= margin_nxt;
    end
  end

  tma_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_channel (in_last_channel),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .stat            (stat),
    .cmd             (cmd)
  );

  tma_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_anchor_value    (in_anchor_value),
    .in_positive_value  (in_positive_value),
    .in_negative_value  (in_negative_value),
    .in_last_sample     (in_last_sample),
    .margin             (margin_r),
    .cmd                (cmd),
    .stat               (stat),
    .out_sample_correct (out_sample_correct),
    .out_batch_done     (out_batch_done),
    .out_correct_total  (out_correct_total),
    .out_samples_total  (out_samples_total),
    .out_batch_accuracy (out_batch_accuracy)
  );

endmodule

`default_nettype wire

### sv/tma_checker.sv
// Port-level checker for the triplet margin accuracy block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "triplet_margin_accuracy_top_macros.svh"

module tma_checker
  import tma_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_sample_correct,
  input wire logic              out_batch_done,
  input wire logic [CNT_W-1:0]  out_correct_total,
  input wire logic [CNT_W-1:0]  out_samples_total,
  input wire logic [ACCQ_W-1:0] out_batch_accuracy
);

  `TMA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_correct_total) && $stable(out_samples_total) && $stable(out_batch_accuracy), "stalled result item changed")
  `TMA_ASSERT(a_acc_zero, out_valid && !out_batch_done |-> out_batch_accuracy == '0, "accuracy set on an item that does not close the batch")
  `TMA_ASSERT(a_count_order, out_valid |-> out_correct_total <= out_samples_total && out_samples_total != '0, "sample counts out of order")
  `TMA_ASSERT(a_acc_full, out_valid && out_batch_done && out_correct_total == out_samples_total |-> out_batch_accuracy == ACCQ_ONE, "accuracy not full with all samples correct")

endmodule

bind triplet_margin_accuracy_top tma_checker u_tma_checker (.*);

`default_nettype wire

### tb/triplet_margin_accuracy_top_test.sv
// Self-checking testbench for the triplet margin accuracy block with randomized handshakes.
`timescale 1ns / 1ps

module triplet_margin_accuracy_top_test;
  import tma_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_CHANNELS = 170;
  localparam logic [ADDR_W-1:0] MARGIN_ADDR = ADDR_W'(REG_MARGIN) << 3;

  typedef struct packed {
    logic signed [FEATURE_BITS-1:0] anchor;
    logic signed [FEATURE_BITS-1:0] positive;
    logic signed [FEATURE_BITS-1:0] negative;
    logic                           last_channel;
    logic                           last_sample;
  } channel_t;

  typedef struct packed {
    logic              sample_correct;
    logic              batch_done;
    logic [CNT_W-1:0]  correct_total;
    logic [CNT_W-1:0]  samples_total;
    logic [ACCQ_W-1:0] batch_accuracy;
  } verdict_t;

  typedef enum int {
    STYLE_WIDE,
    STYLE_NARROW,
    STYLE_NEAR_POSITIVE,
    STYLE_NEAR_NEGATIVE
  } feature_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [FEATURE_BITS-1:0] in_anchor_value = '0;
  logic signed [FEATURE_BITS-1:0] in_positive_value = '0;
  logic signed [FEATURE_BITS-1:0] in_negative_value = '0;
  logic in_last_channel = 1'b0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_sample_correct;
  logic out_batch_done;
  logic [CNT_W-1:0] out_correct_total;
  logic [CNT_W-1:0] out_samples_total;
  logic [ACCQ_W-1:0] out_batch_accuracy;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  channel_t pending_channels[$];
  verdict_t expected_verdicts[$];
  channel_t presented;
  int feed_gap = 0;
  int stall_left = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;
  int mismatches = 0;

  logic signed [ACC_W-1:0] margin_model = '0;
  logic [ACC_W-1:0] ap_dist = '0;
  logic [ACC_W-1:0] an_dist = '0;
  int correct_count = 0;
  int sample_count = 0;

  triplet_margin_accuracy_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_anchor_value    (in_anchor_value),
    .in_positive_value  (in_positive_value),
    .in_negative_value  (in_negative_value),
    .in_last_channel    (in_last_channel),
    .in_last_sample     (in_last_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample_correct (out_sample_correct),
    .out_batch_done     (out_batch_done),
    .out_correct_total  (out_correct_total),
    .out_samples_total  (out_samples_total),
    .out_batch_accuracy (out_batch_accuracy),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [ACC_W-1:0] squared_gap(logic signed [FEATURE_BITS-1:0] x,
                                                   logic signed [FEATURE_BITS-1:0] y);
    longint signed d;
    d = longint'(x) - longint'(y);
    return ACC_W'(d * d);
  endfunction

  function automatic logic [ACC_W-1:0] clip_add(logic [ACC_W-1:0] acc, logic [ACC_W-1:0] x);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + {1'b0, x};
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

  function automatic void score_channel(channel_t ch);
    longint signed verdict;
    bit correct;
    verdict_t v;
    ap_dist = clip_add(ap_dist, squared_gap(ch.anchor, ch.positive));
    an_dist = clip_add(an_dist, squared_gap(ch.anchor, ch.negative));
    if (ch.last_channel) begin
      verdict = longint'(margin_model) + longint'(ap_dist) - longint'(an_dist);
      correct = (verdict <= 0);
      ap_dist = '0;
      an_dist = '0;
      if (sample_count < MAX_BATCH) begin
        sample_count++;
        if (correct) correct_count++;
      end
      v.sample_correct = correct;
      v.batch_done = ch.last_sample;
      v.correct_total = CNT_W'(correct_count);
      v.samples_total = CNT_W'(sample_count);
      v.batch_accuracy = ch.last_sample ?
                         ACCQ_W'((longint'(correct_count) << 16) / sample_count) : '0;
      if (ch.last_sample) begin
        correct_count = 0;
        sample_count = 0;
      end
      expected_verdicts.push_back(v);
    end
  endfunction

  function automatic int field_mismatch(string field, logic [ACCQ_W-1:0] want,
                                        logic [ACCQ_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic logic signed [FEATURE_BITS-1:0] draw_feature(bit narrow);
    case ($urandom_range(0, 9))
      0: return {1'b0, {(FEATURE_BITS-1){1'b1}}};
      1: return {1'b1, {(FEATURE_BITS-1){1'b0}}};
      default: begin
        if (narrow) return FEATURE_BITS'(int'($urandom_range(0, 1023)) - 512);
        return FEATURE_BITS'($urandom);
      end
    endcase
  endfunction

  function automatic logic signed [FEATURE_BITS-1:0] near(logic signed [FEATURE_BITS-1:0] x);
    return x + FEATURE_BITS'(int'($urandom_range(0, 63)) - 32);
  endfunction

  function automatic logic signed [ACC_W-1:0] pick_margin();
    logic signed [ACC_W-1:0] raw;
    raw = ACC_W'({$urandom, $urandom});
    return raw >>> $urandom_range(12, 30);
  endfunction

  function automatic void push_channel(logic signed [FEATURE_BITS-1:0] a,
                                       logic signed [FEATURE_BITS-1:0] p,
                                       logic signed [FEATURE_BITS-1:0] n,
                                       logic lc, logic ls);
    channel_t ch;
    ch.anchor = a;
    ch.positive = p;
    ch.negative = n;
    ch.last_channel = lc;
    ch.last_sample = ls;
    pending_channels.push_back(ch);
  endfunction

  function automatic void queue_sample(int channels, bit closes_batch, feature_style_t style);
    logic signed [FEATURE_BITS-1:0] a;
    logic signed [FEATURE_BITS-1:0] p;
    logic signed [FEATURE_BITS-1:0] n;
    bit narrow;
    bit closing;
    narrow = (style != STYLE_WIDE);
    for (int i = 0; i < channels; i++) begin
      closing = (i == channels - 1);
      a = draw_feature(narrow);
      p = (style == STYLE_NEAR_POSITIVE) ? near(a) : draw_feature(narrow);
      n = (style == STYLE_NEAR_NEGATIVE) ? near(a) : draw_feature(narrow);
      push_channel(a, p, n, closing,
                   closing ? closes_batch : ($urandom_range(0, 7) == 0));
    end
  endfunction

  task automatic apb_cycle(input bit wr, input logic [DATA_W-1:0] wdata,
                           output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= MARGIN_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_margin(input logic signed [ACC_W-1:0] value);
    logic [DATA_W-1:0] rdata;
    apb_cycle(1'b1, DATA_W'(value), rdata);
    margin_model = value;
    apb_cycle(1'b0, '0, rdata);
    if (rdata[ACC_W-1:0] !== value) begin
      $error("margin expected %0d got %0d", value, $signed(rdata[ACC_W-1:0]));
      mismatches++;
    end
  endtask

  task automatic drain();
    while (pending_channels.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    channel_t next_ch;
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (in_valid && !in_stall) score_channel(presented);
      if (!in_valid || !in_stall) begin
        if (feed_gap > 0) begin
          in_valid <= 1'b0;
          feed_gap <= feed_gap - 1;
        end else if (pending_channels.size() != 0) begin
          next_ch = pending_channels.pop_front();
          presented <= next_ch;
          in_anchor_value <= next_ch.anchor;
          in_positive_value <= next_ch.positive;
          in_negative_value <= next_ch.negative;
          in_last_channel <= next_ch.last_channel;
          in_last_sample <= next_ch.last_sample;
          in_valid <= 1'b1;
          feed_gap <= in_idle_on ? $urandom_range(0, 4) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    int hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid && !out_stall) begin
        got.sample_correct = out_sample_correct;
        got.batch_done = out_batch_done;
        got.correct_total = out_correct_total;
        got.samples_total = out_samples_total;
        got.batch_accuracy = out_batch_accuracy;
        if (expected_verdicts.size() == 0) begin
          $error("result with no item pending: correct_total %0d samples_total %0d",
                 got.correct_total, got.samples_total);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          mismatches += field_mismatch("sample_correct", want.sample_correct,
                                       got.sample_correct);
          mismatches += field_mismatch("batch_done", want.batch_done, got.batch_done);
          mismatches += field_mismatch("correct_total", want.correct_total,
                                       got.correct_total);
          mismatches += field_mismatch("samples_total", want.samples_total,
                                       got.samples_total);
          mismatches += field_mismatch("batch_accuracy", want.batch_accuracy,
                                       got.batch_accuracy);
        end
        hold = out_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  initial begin
    int queued;
    int channels;
    int batch;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset margin of zero: boundary verdicts, field extremes and a stray last_sample.
    push_channel(0, 0, 0, 1'b1, 1'b1);
    push_channel(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 1'b0);
    push_channel(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b1);
    push_channel(0, 0, 0, 1'b1, 1'b0);
    push_channel(1, 0, 0, 1'b1, 1'b0);
    push_channel(-1, -1, 1, 1'b1, 1'b1);
    drain();

    program_margin({1'b0, {(ACC_W-1){1'b1}}});
    push_channel(5, 3, -7, 1'b1, 1'b1);
    drain();

    program_margin({1'b1, {(ACC_W-1){1'b0}}});
    push_channel(16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, 1'b0);
    push_channel(16'sh8000, 16'sh7fff, 0, 1'b1, 1'b1);
    drain();

    program_margin(1);
    push_channel(2, 1, 1, 1'b1, 1'b0);
    push_channel(2, 1, 0, 1'b1, 1'b1);
    drain();

    program_margin(-3);
    push_channel(0, 1, 2, 1'b1, 1'b1);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      in_idle_on = (phase % 3) != 1;
      out_idle_on = (phase % 4) != 2;
      program_margin(pick_margin());
      queued = 0;
      while (queued < PHASE_CHANNELS) begin
        batch = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int s = 0; s < batch; s++) begin
          channels = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
          queue_sample(channels, s == batch - 1, feature_style_t'($urandom_range(0, 3)));
          queued += channels;
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
